// ===== hw/rtl/vsd_pkg.sv =====
package vsd_pkg;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned LEN_W   = 4;
    localparam int unsigned FMT_W   = 2;
    localparam int unsigned PAY_W   = 7;

    // format_select bits
    localparam int unsigned FMT_FLAG_HIGH   = 0;
    localparam int unsigned FMT_SET_TERM    = 1;

    localparam logic [7:0] PAYLOAD_MASK_HIGH = 8'h7f;
    localparam logic [7:0] PAYLOAD_MASK_LOW  = 8'hfe;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } in_word_t;

    typedef struct packed {
        logic [VALUE_W-1:0] varint_value;
        logic [LEN_W-1:0]   byte_length;
        logic               decode_error;
    } out_word_t;

    typedef struct packed {
        logic [PAY_W-1:0] payload;
        logic             terminator;
    } unpack_t;

    typedef struct packed {
        logic      emit;
        out_word_t word;
    } step_result_t;

endpackage

// ===== hw/rtl/varint_stream_decoder.sv =====
// channel | dir | handshake           | word
// in      | in  | in_valid / in_stall | data_byte, buffer_end
// out     | out | out_valid/out_stall | varint_value, byte_length, decode_error
// cfg     | in  | cfg_valid/cfg_ready | format_select (2 bits)
//
// One word per cycle sustained while the output does not stall; a result is on
// the output once its last byte has passed the input register, then the result register.
// Reset clears the accumulator, byte count, format and both valid flags.
// Output stall only holds the input side when the waiting word produces a
// result; continuing bytes pass through regardless.
module varint_stream_decoder
#(
    parameter int unsigned MAX_BYTES = 10
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  vsd_pkg::in_word_t           in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output vsd_pkg::out_word_t          out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [vsd_pkg::FMT_W-1:0]   cfg_data
);

    logic                        in_valid_reg, in_valid_next;
    vsd_pkg::in_word_t           in_word_reg, in_word_next;
    logic                        out_valid_reg, out_valid_next;
    vsd_pkg::out_word_t          out_word_reg, out_word_next;
    logic [vsd_pkg::FMT_W-1:0]   format_reg, format_next;

    vsd_pkg::step_result_t       step_res;
    logic                        advance;

    vsd_core #(.MAX_BYTES(MAX_BYTES)) u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (advance),
        .in_word       (in_word_reg),
        .format_select (format_reg),
        .result        (step_res)
    );

    assign advance   = in_valid_reg && (!step_res.emit || !out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_word_next   = in_word_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        format_next    = format_reg;

        if (!in_stall)
        begin
            in_valid_next = in_valid;
            in_word_next  = in_data;
        end

        if (advance && step_res.emit)
        begin
            out_valid_next = 1'b1;
            out_word_next  = step_res.word;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            format_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            format_reg    <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            format_reg    <= format_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_word_reg  <= in_word_next;
        out_word_reg <= out_word_next;
    end

    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && step_res.emit && out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

    a_held_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> (in_valid_reg && $stable(in_word_reg)))
        else $error("stalled input word lost");

    a_error_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.decode_error) |->
            (out_word_reg.varint_value == '0 && out_word_reg.byte_length == '0))
        else $error("error result carries nonzero value or length");

endmodule

// ===== hw/rtl/vsd_unpack.sv =====
module vsd_unpack
(
    input  logic [7:0]                     data_byte,
    input  logic [vsd_pkg::FMT_W-1:0]      format_select,
    output vsd_pkg::unpack_t               fields
);

    logic flag;
    logic [7:0] masked;

    always_comb
    begin
        if (format_select[vsd_pkg::FMT_FLAG_HIGH])
        begin
            masked         = data_byte & vsd_pkg::PAYLOAD_MASK_HIGH;
            fields.payload = masked[vsd_pkg::PAY_W-1:0];
            flag           = data_byte[7];
        end
        else
        begin
            masked         = data_byte & vsd_pkg::PAYLOAD_MASK_LOW;
            fields.payload = masked[7:1];
            flag           = data_byte[0];
        end
        fields.terminator = format_select[vsd_pkg::FMT_SET_TERM] ? flag : !flag;
    end

endmodule

// ===== hw/rtl/vsd_core.sv =====
module vsd_core
#(
    parameter int unsigned MAX_BYTES = 10
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step_en,
    input  vsd_pkg::in_word_t           in_word,
    input  logic [vsd_pkg::FMT_W-1:0]   format_select,
    output vsd_pkg::step_result_t       result
);

    localparam logic [vsd_pkg::LEN_W-1:0] MAX_LEN = vsd_pkg::LEN_W'(MAX_BYTES);

    logic [vsd_pkg::VALUE_W-1:0] acc_reg, acc_next;
    logic [vsd_pkg::LEN_W-1:0]   count_reg, count_next;

    vsd_pkg::unpack_t            fields;
    logic [5:0]                  shift;
    logic [vsd_pkg::VALUE_W-1:0] merged;
    logic [vsd_pkg::LEN_W-1:0]   pos;

    vsd_unpack u_unpack
    (
        .data_byte     (in_word.data_byte),
        .format_select (format_select),
        .fields        (fields)
    );

    // count stays below MAX_BYTES, so with the default of 10 the shift stays below 64
    always_comb
    begin
        shift  = 6'({count_reg, 3'b000} - {3'b000, count_reg});
        merged = acc_reg | ({{(vsd_pkg::VALUE_W-vsd_pkg::PAY_W){1'b0}}, fields.payload} << shift);
        pos    = count_reg + 1'b1;

        result.emit               = 1'b0;
        result.word.varint_value  = '0;
        result.word.byte_length   = '0;
        result.word.decode_error  = 1'b0;
        acc_next                  = acc_reg;
        count_next                = count_reg;

        if (fields.terminator)
        begin
            result.emit               = 1'b1;
            result.word.varint_value  = merged;
            result.word.byte_length   = pos;
        end
        else if (pos >= MAX_LEN || in_word.buffer_end)
        begin
            result.emit              = 1'b1;
            result.word.decode_error = 1'b1;
        end

        if (step_en)
        begin
            if (result.emit)
            begin
                acc_next   = '0;
                count_next = '0;
            end
            else
            begin
                acc_next   = merged;
                count_next = pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            acc_reg   <= acc_next;
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < MAX_LEN)
        else $error("byte count reached the length limit without reset");

    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && result.emit) |=> (acc_reg == '0 && count_reg == '0))
        else $error("state not cleared after a result");

    a_len_on_success: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && result.emit && !result.word.decode_error) |->
            (result.word.byte_length != '0))
        else $error("successful result with zero length");

endmodule
